// ===== src/lts_pkg.sv =====
// Shared constants, register codes and character helpers for the literal
// text search block. Used by the channel interfaces and by the top level.
// No dependencies.
package lts_pkg;

  // Pattern storage and the character window behind it.
  localparam int PATTERN_MAX  = 32;
  localparam int PATTERN_CAP  = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
  localparam int WINDOW_DEPTH = PATTERN_MAX + 1;
  localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int PAT_WORDS    = 4;

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int LINE_W     = 32;
  localparam int COL_W      = 24;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Counter ceilings.
  localparam logic [LINE_W-1:0] LINE_CEIL = '1;
  localparam logic [COL_W-1:0]  COL_CEIL  = '1;

  // Characters with a special meaning.
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_US = 8'h5F;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7      = 3'd0,
    REG_PAT_8_15     = 3'd1,
    REG_PAT_16_23    = 3'd2,
    REG_PAT_24_31    = 3'd3,
    REG_PAT_LENGTH   = 3'd4,
    REG_MATCH_CASE   = 3'd5,
    REG_WHOLE_WORD   = 3'd6
  } cfg_reg_e;

  // Underscore, digit or ASCII letter.
  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return (c == CHAR_US) ||
           (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Map upper-case ASCII letters to lower case.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

endpackage

// ===== src/lts_if.sv =====
// Valid/ready channel interfaces of the literal text search block:
// text input, match output and configuration writes.
// Depends on lts_pkg.
interface lts_in_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::CHAR_W-1:0] character;
  logic                       end_of_text;

  modport source (output valid, character, end_of_text, input ready);
  modport sink   (input valid, character, end_of_text, output ready);
endinterface

interface lts_out_if;
  logic                       valid;
  logic                       ready;
  logic [lts_pkg::LINE_W-1:0] line_no;
  logic [lts_pkg::COL_W-1:0]  column;
  logic                       last_of_run;

  modport source (output valid, line_no, column, last_of_run, input ready);
  modport sink   (input valid, line_no, column, last_of_run, output ready);
endinterface

interface lts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lts_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [lts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== src/literal_text_search_with_lines.sv =====
// Top level of the literal text search block: line splitting, window
// compare, whole-word filter and match output register.
// Depends on lts_pkg and the interfaces in lts_if.sv.
//
//   Channel   Dir  Beat carries                          Accepted when
//   cfg_i     in   reg_index, data                       valid && ready
//   text_i    in   character, end_of_text                valid && ready
//   match_o   out  line_no, column, last_of_run          valid && ready
//
// One character per cycle while the match output keeps up. A character
// is registered, then compared against the 33-character window while
// the line state updates. A character that yields two matches holds the
// output register for two beats, so text input can stall behind it.
// Reset clears the window, column count and pattern at once and sets line 1
// and match-case; there is no clearing pass. Configuration writes are always taken.
module literal_text_search_with_lines (
  input logic      clk_i,
  input logic      rst_ni,
  lts_cfg_if.sink  cfg_i,
  lts_in_if.sink   text_i,
  lts_out_if.source match_o
);

  // Configuration registers.
  logic [lts_pkg::CFG_DATA_W-1:0] pat_words_q [lts_pkg::PAT_WORDS];
  logic [lts_pkg::LEN_W-1:0]      pat_len_q;
  logic                           match_case_q;
  logic                           whole_word_q;

  // Input register.
  logic                       in_valid_q;
  logic [lts_pkg::CHAR_W-1:0] in_char_q;
  logic                       in_eot_q;

  // Line state.
  logic [lts_pkg::CHAR_W-1:0] win_q [lts_pkg::WINDOW_DEPTH];
  logic [lts_pkg::CHAR_W-1:0] win_d [lts_pkg::WINDOW_DEPTH];
  logic [lts_pkg::COL_W-1:0]  col_cnt_q, col_cnt_d;
  logic [lts_pkg::LINE_W-1:0] line_q, line_d;
  logic                       prev_cr_q, prev_cr_d;
  logic                       pend_valid_q, pend_valid_d;
  logic [lts_pkg::COL_W-1:0]  pend_col_q, pend_col_d;

  // Result register, up to two matches for one character.
  logic                       res_valid_q;
  logic                       res_two_q;
  logic                       res_sel_q;
  logic [lts_pkg::LINE_W-1:0] res_line_q;
  logic [lts_pkg::COL_W-1:0]  res_col0_q;
  logic [lts_pkg::COL_W-1:0]  res_col1_q;

  // Compare results.
  logic                       emit_first;
  logic                       emit_second;
  logic [lts_pkg::COL_W-1:0]  first_col;
  logic [lts_pkg::COL_W-1:0]  match_col;

  logic res_last;
  logic res_free;
  logic advance;
  logic text_beat;
  logic match_beat;

  // Configuration write port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < lts_pkg::PAT_WORDS; w++) begin
        pat_words_q[w] <= '0;
      end
      pat_len_q    <= '0;
      match_case_q <= 1'b1;
      whole_word_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (lts_pkg::cfg_reg_e'(cfg_i.reg_index))
        lts_pkg::REG_PAT_0_7, lts_pkg::REG_PAT_8_15,
        lts_pkg::REG_PAT_16_23, lts_pkg::REG_PAT_24_31: begin
          pat_words_q[cfg_i.reg_index[1:0]] <= cfg_i.data;
        end
        lts_pkg::REG_PAT_LENGTH: pat_len_q    <= cfg_i.data[lts_pkg::LEN_W-1:0];
        lts_pkg::REG_MATCH_CASE: match_case_q <= cfg_i.data[0];
        lts_pkg::REG_WHOLE_WORD: whole_word_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Handshake control: the input register moves on when the result
  // register is empty or hands over its last beat in this cycle.
  assign res_last      = !res_two_q || res_sel_q;
  assign res_free      = !res_valid_q || (match_o.ready && res_last);
  assign advance       = in_valid_q && res_free;
  assign text_i.ready  = !in_valid_q || res_free;
  assign text_beat     = text_i.valid && text_i.ready;
  assign match_beat    = match_o.valid && match_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_beat) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_beat) begin
      in_char_q <= text_i.character;
      in_eot_q  <= text_i.end_of_text;
    end
  end

  // Character handling, window compare and next line state.
  always_comb begin
    logic                        is_cr;
    logic                        is_lf;
    logic                        ends_line;
    logic                        plain;
    logic [lts_pkg::LEN_W-1:0]   eff_len;
    logic [lts_pkg::CHAR_W-1:0]  shifted [lts_pkg::WINDOW_DEPTH];
    logic [lts_pkg::COL_W-1:0]   cnt_inc;
    logic [lts_pkg::LINE_W-1:0]  line_inc;
    logic [lts_pkg::WIN_IDX_W-1:0] t_idx;
    logic [lts_pkg::WIN_IDX_W-1:0] first_idx;
    logic [lts_pkg::WIN_IDX_W-1:0] prev_idx;
    logic [lts_pkg::CHAR_W-1:0]  p_ch;
    logic [lts_pkg::CHAR_W-1:0]  t_ch;
    logic [lts_pkg::CHAR_W-1:0]  first_ch;
    logic                        all_eq;
    logic                        hit;
    logic                        before_ok;
    logic                        new_pend;

    is_cr     = (in_char_q == lts_pkg::CHAR_CR);
    is_lf     = (in_char_q == lts_pkg::CHAR_LF);
    ends_line = is_cr || (is_lf && !prev_cr_q);
    plain     = !is_cr && !is_lf;

    eff_len = (pat_len_q > lts_pkg::LEN_W'(lts_pkg::PATTERN_CAP)) ?
              lts_pkg::LEN_W'(lts_pkg::PATTERN_CAP) : pat_len_q;

    // Window as it stands once this character is shifted in.
    shifted[0] = in_char_q;
    for (int k = 1; k < lts_pkg::WINDOW_DEPTH; k++) begin
      shifted[k] = win_q[k-1];
    end

    cnt_inc  = (col_cnt_q == lts_pkg::COL_CEIL) ? col_cnt_q :
               col_cnt_q + lts_pkg::COL_W'(1);
    line_inc = (line_q == lts_pkg::LINE_CEIL) ? line_q :
               line_q + lts_pkg::LINE_W'(1);

    // Pattern character i lines up with window slot len-1-i.
    all_eq = 1'b1;
    t_idx  = '0;
    for (int i = 0; i < lts_pkg::PATTERN_CAP; i++) begin
      p_ch  = pat_words_q[i / 8][(i % 8) * 8 +: 8];
      t_idx = lts_pkg::WIN_IDX_W'(eff_len) - lts_pkg::WIN_IDX_W'(i) -
              lts_pkg::WIN_IDX_W'(1);
      t_ch  = (lts_pkg::LEN_W'(i) < eff_len) ? shifted[t_idx] : '0;
      if (!match_case_q) begin
        p_ch = lts_pkg::fold_case(p_ch);
        t_ch = lts_pkg::fold_case(t_ch);
      end
      if ((lts_pkg::LEN_W'(i) < eff_len) && (p_ch != t_ch)) begin
        all_eq = 1'b0;
      end
    end

    hit = plain && (eff_len != '0) && all_eq &&
          (cnt_inc >= lts_pkg::COL_W'(eff_len));

    match_col = (cnt_inc == lts_pkg::COL_CEIL) ? lts_pkg::COL_CEIL :
                cnt_inc - lts_pkg::COL_W'(eff_len) + lts_pkg::COL_W'(1);

    // Word boundary in front of the match.
    first_idx = (eff_len == '0) ? '0 :
                lts_pkg::WIN_IDX_W'(eff_len) - lts_pkg::WIN_IDX_W'(1);
    prev_idx  = lts_pkg::WIN_IDX_W'(eff_len);
    first_ch  = shifted[first_idx];
    before_ok = (match_col == lts_pkg::COL_W'(1)) ?
                lts_pkg::is_word_char(first_ch) :
                (lts_pkg::is_word_char(shifted[prev_idx]) !=
                 lts_pkg::is_word_char(first_ch));
    new_pend  = hit && whole_word_q && before_ok;

    // A pending match is decided by a line end or by the next character.
    emit_first = pend_valid_q && (
                   (ends_line && lts_pkg::is_word_char(win_q[0])) ||
                   (plain && (lts_pkg::is_word_char(win_q[0]) !=
                              lts_pkg::is_word_char(in_char_q))));
    first_col  = pend_col_q;

    // Direct match, or a fresh pending match closed by the end of text.
    emit_second = hit && (!whole_word_q ||
                  (new_pend && in_eot_q && lts_pkg::is_word_char(in_char_q)));

    // Next state.
    win_d        = win_q;
    col_cnt_d    = col_cnt_q;
    line_d       = line_q;
    prev_cr_d    = prev_cr_q;
    pend_valid_d = pend_valid_q;
    pend_col_d   = pend_col_q;

    if (ends_line) begin
      pend_valid_d = 1'b0;
      col_cnt_d    = '0;
      line_d       = line_inc;
      prev_cr_d    = is_cr;
    end else if (is_lf) begin
      prev_cr_d = 1'b0;
    end else begin
      prev_cr_d    = 1'b0;
      win_d        = shifted;
      col_cnt_d    = cnt_inc;
      pend_valid_d = new_pend;
      if (new_pend) begin
        pend_col_d = match_col;
      end
    end

    // End of text starts a fresh text.
    if (in_eot_q) begin
      for (int k = 0; k < lts_pkg::WINDOW_DEPTH; k++) begin
        win_d[k] = '0;
      end
      col_cnt_d    = '0;
      line_d       = lts_pkg::LINE_W'(1);
      prev_cr_d    = 1'b0;
      pend_valid_d = 1'b0;
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lts_pkg::WINDOW_DEPTH; k++) begin
        win_q[k] <= '0;
      end
      col_cnt_q    <= '0;
      line_q       <= lts_pkg::LINE_W'(1);
      prev_cr_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_col_q   <= '0;
    end else if (advance) begin
      win_q        <= win_d;
      col_cnt_q    <= col_cnt_d;
      line_q       <= line_d;
      prev_cr_q    <= prev_cr_d;
      pend_valid_q <= pend_valid_d;
      pend_col_q   <= pend_col_d;
    end
  end

  // Result register control: load on a character with matches, step
  // through one or two beats on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_two_q   <= 1'b0;
      res_sel_q   <= 1'b0;
    end else if (advance && (emit_first || emit_second)) begin
      res_valid_q <= 1'b1;
      res_two_q   <= emit_first && emit_second;
      res_sel_q   <= 1'b0;
    end else if (match_beat) begin
      if (res_last) begin
        res_valid_q <= 1'b0;
      end else begin
        res_sel_q <= 1'b1;
      end
    end
  end

  // All matches of one character lie on the same line.
  always_ff @(posedge clk_i) begin
    if (advance && (emit_first || emit_second)) begin
      res_line_q <= line_q;
      res_col0_q <= emit_first ? first_col : match_col;
      res_col1_q <= match_col;
    end
  end

  assign match_o.valid       = res_valid_q;
  assign match_o.line_no     = res_line_q;
  assign match_o.column      = res_sel_q ? res_col1_q : res_col0_q;
  assign match_o.last_of_run = res_last;

endmodule

// ===== src/lts_checker.sv =====
// Port-level checks for the literal text search block, attached to the
// top level by the bind statement at the end of this file.
// Depends on lts_pkg and the top level literal_text_search_with_lines.
module lts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       match_valid_i,
  input logic                       match_ready_i,
  input logic [lts_pkg::LINE_W-1:0] line_no_i,
  input logic [lts_pkg::COL_W-1:0]  column_i,
  input logic                       last_of_run_i
);

  // A shown beat stays until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_i && !match_ready_i |=> match_valid_i)
    else $error("match beat dropped before it was taken");

  // A stalled beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_i && !match_ready_i |=>
      $stable(line_no_i) && $stable(column_i) && $stable(last_of_run_i))
    else $error("match payload changed while stalled");

  // Line and column are 1-based.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_i |-> (line_no_i != '0) && (column_i != '0))
    else $error("match reported at line or column zero");

  // The second match of a run follows at once, on the same line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_valid_i && match_ready_i && !last_of_run_i |=>
      match_valid_i && last_of_run_i && (line_no_i == $past(line_no_i)))
    else $error("second match of a run out of order");

endmodule

bind literal_text_search_with_lines lts_checker u_lts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .match_valid_i (match_o.valid),
  .match_ready_i (match_o.ready),
  .line_no_i     (match_o.line_no),
  .column_i      (match_o.column),
  .last_of_run_i (match_o.last_of_run)
);
